>>> rtl/prime_sieve_counter_assert.svh
// assertion macros for the prime sieve counter
`ifndef PRIME_SIEVE_COUNTER_ASSERT_SVH
`define PRIME_SIEVE_COUNTER_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define PSC_ASSERT_IMPLY(label, rst, ante, cons) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |-> (cons)) \
      else $error("prime sieve counter check failed");

// next-cycle implication, sampled on clock, off during reset
`define PSC_ASSERT_NEXT(label, rst, ante, cons) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |=> (cons)) \
      else $error("prime sieve counter sequence check failed");

`endif

>>> rtl/psc_pkg.sv
// shared types for the prime sieve counter
package psc_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_BASE_CHECK,
      ST_BASE_TEST,
      ST_MARK,
      ST_SCAN,
      ST_SCAN_LAST,
      ST_DONE
   } psc_state_type;

   typedef struct packed {
      logic load;
      logic init_write;
      logic base_read;
      logic base_next;
      logic mark_start;
      logic mark_write;
      logic scan_start;
      logic scan_read;
   } psc_cmd_type;

   typedef struct packed {
      logic small_limit;
      logic addr_last;
      logic base_done;
      logic flag_set;
      logic mark_done;
   } psc_status_type;

endpackage

>>> rtl/psc_ctrl.sv
// sequencing state machine for the prime sieve counter
`include "prime_sieve_counter_assert.svh"

module psc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  psc_pkg::psc_status_type  status,
   output psc_pkg::psc_cmd_type     cmd,
   output logic                     busy,
   output logic                     done
);

   psc_pkg::psc_state_type state_ff;
   psc_pkg::psc_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         psc_pkg::ST_IDLE: begin
            if (start) begin
               state_in = status.small_limit ? psc_pkg::ST_DONE : psc_pkg::ST_INIT;
            end
         end
         psc_pkg::ST_INIT: begin
            if (status.addr_last) begin
               state_in = psc_pkg::ST_BASE_CHECK;
            end
         end
         psc_pkg::ST_BASE_CHECK: begin
            state_in = status.base_done ? psc_pkg::ST_SCAN : psc_pkg::ST_BASE_TEST;
         end
         psc_pkg::ST_BASE_TEST: begin
            state_in = status.flag_set ? psc_pkg::ST_MARK : psc_pkg::ST_BASE_CHECK;
         end
         psc_pkg::ST_MARK: begin
            if (status.mark_done) begin
               state_in = psc_pkg::ST_BASE_CHECK;
            end
         end
         psc_pkg::ST_SCAN: begin
            if (status.addr_last) begin
               state_in = psc_pkg::ST_SCAN_LAST;
            end
         end
         psc_pkg::ST_SCAN_LAST: begin
            state_in = psc_pkg::ST_DONE;
         end
         psc_pkg::ST_DONE: begin
            state_in = psc_pkg::ST_IDLE;
         end
         default: begin
            state_in = psc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      done = 1'b0;
      case (state_ff)
         psc_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         psc_pkg::ST_INIT: begin
            cmd.init_write = 1'b1;
         end
         psc_pkg::ST_BASE_CHECK: begin
            cmd.scan_start = status.base_done;
            cmd.base_read  = !status.base_done;
         end
         psc_pkg::ST_BASE_TEST: begin
            cmd.mark_start = status.flag_set;
            cmd.base_next  = !status.flag_set;
         end
         psc_pkg::ST_MARK: begin
            cmd.base_next  = status.mark_done;
            cmd.mark_write = !status.mark_done;
         end
         psc_pkg::ST_SCAN: begin
            cmd.scan_read = 1'b1;
         end
         psc_pkg::ST_SCAN_LAST: begin
            cmd = '0;
         end
         psc_pkg::ST_DONE: begin
            done = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   `PSC_ASSERT_NEXT(a_load_enters_run, reset, cmd.load,
      state_ff == psc_pkg::ST_INIT || state_ff == psc_pkg::ST_DONE)
   `PSC_ASSERT_NEXT(a_done_one_cycle, reset, done, !done && !busy)
   `PSC_ASSERT_IMPLY(a_mark_in_range, reset, cmd.mark_write, !status.mark_done)
   `PSC_ASSERT_IMPLY(a_base_in_range, reset, cmd.base_read, !status.base_done)

endmodule

>>> rtl/psc_datapath.sv
// flag memory, counters and prime count register for the prime sieve counter
module psc_datapath #(
   parameter int MAX_LIMIT = 65535
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [15:0]              req_limit,
   input  psc_pkg::psc_cmd_type     cmd,
   output psc_pkg::psc_status_type  status,
   output logic [15:0]              rsp_prime_count
);

   localparam int AW    = $clog2(MAX_LIMIT + 1);
   localparam int LW    = (AW > 16) ? AW : 16;
   localparam int DEPTH = MAX_LIMIT + 1;

   logic            flags_mem [DEPTH];

   logic [AW-1:0]   n_ff, n_in;
   logic [AW-1:0]   p_ff, p_in;
   logic [AW:0]     sq_ff, sq_in;
   logic [AW:0]     m_ff, m_in;
   logic [AW:0]     addr_ff, addr_in;
   logic [15:0]     count_ff, count_in;
   logic            scan_valid_ff;
   logic            rd_data_ff;

   logic [LW-1:0]   limit_ext;
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic            wr_data;
   logic            rd_en;
   logic [AW-1:0]   rd_addr;

   assign limit_ext = LW'(req_limit);

   always_comb begin
      n_in     = n_ff;
      p_in     = p_ff;
      sq_in    = sq_ff;
      m_in     = m_ff;
      addr_in  = addr_ff;
      count_in = count_ff;
      if (cmd.load) begin
         if (limit_ext > LW'(MAX_LIMIT)) begin
            n_in = AW'(MAX_LIMIT);
         end else begin
            n_in = AW'(limit_ext);
         end
         p_in     = AW'(2);
         sq_in    = (AW + 1)'(4);
         addr_in  = '0;
         count_in = '0;
      end
      if (cmd.init_write || cmd.scan_read) begin
         addr_in = addr_ff + (AW + 1)'(1);
      end
      if (cmd.scan_start) begin
         addr_in = (AW + 1)'(2);
      end
      if (cmd.base_next) begin
         p_in  = p_ff + AW'(1);
         sq_in = sq_ff + {p_ff, 1'b1};
      end
      if (cmd.mark_start) begin
         m_in = sq_ff;
      end
      if (cmd.mark_write) begin
         m_in = m_ff + (AW + 1)'(p_ff);
      end
      if (scan_valid_ff) begin
         count_in = count_ff + 16'(rd_data_ff);
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      p_ff     <= p_in;
      sq_ff    <= sq_in;
      m_ff     <= m_in;
      addr_ff  <= addr_in;
      count_ff <= count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_valid_ff <= 1'b0;
      end else begin
         scan_valid_ff <= cmd.scan_read;
      end
   end

   // single write port: init fill or clearing a multiple
   always_comb begin
      wr_en   = cmd.init_write || cmd.mark_write;
      wr_addr = cmd.mark_write ? m_ff[AW-1:0] : addr_ff[AW-1:0];
      wr_data = cmd.init_write && (addr_ff >= (AW + 1)'(2));
      rd_en   = cmd.base_read || cmd.scan_read;
      rd_addr = cmd.base_read ? p_ff : addr_ff[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         flags_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= flags_mem[rd_addr];
      end
   end

   always_comb begin
      status.small_limit = req_limit <= 16'd1;
      status.addr_last   = addr_ff == {1'b0, n_ff};
      status.base_done   = sq_ff > {1'b0, n_ff};
      status.flag_set    = rd_data_ff;
      status.mark_done   = m_ff > {1'b0, n_ff};
   end

   assign rsp_prime_count = count_ff;

endmodule

>>> rtl/prime_sieve_counter.sv
// top level of the prime sieve counter
// Takes a limit n on req_limit when start is high and busy is low, and returns the
// number of primes from 2 to n on rsp_prime_count, marked by rsp_valid for exactly one
// cycle; the receiver cannot stall, so the count must be taken in that cycle. Limits
// above MAX_LIMIT are treated as MAX_LIMIT, and a limit of 0 or 1 answers 0 in the
// cycle after acceptance. Otherwise the flag memory, which has one write and one read
// port, is filled; each base is then tested in the BASE_CHECK and BASE_TEST states,
// and each prime base has its multiples cleared (about n log log n in all); finally
// the flags from 2 to n are read and counted. The fill, the clearing and the final
// count each handle the flags one at a time. busy stays high from acceptance through
// the result cycle, so the next item can be accepted in the cycle after the result.
module prime_sieve_counter #(
   parameter int MAX_LIMIT = 65535
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] req_limit,
   output logic        busy,
   output logic        rsp_valid,
   output logic [15:0] rsp_prime_count
);

   psc_pkg::psc_cmd_type    cmd;
   psc_pkg::psc_status_type status;

   psc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy),
      .done   (rsp_valid)
   );

   psc_datapath #(
      .MAX_LIMIT (MAX_LIMIT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_limit       (req_limit),
      .cmd             (cmd),
      .status          (status),
      .rsp_prime_count (rsp_prime_count)
   );

endmodule
